@@ src/mcw_pkg.sv @@
// Package for the motor command controller with watchdog.
// Holds the request, response and state types, command codes and the duty helper.
// No dependencies.
package mcw_pkg;

  localparam logic [7:0] CMD_SET    = 8'h01;
  localparam logic [7:0] CMD_STOP   = 8'h02;
  localparam logic [7:0] CMD_STATUS = 8'h03;

  localparam logic [4:0] SET_MIN_LEN = 5'd4;

  localparam logic       FUNC_FRAME = 1'b0;
  localparam logic       FUNC_TICK  = 1'b1;

  localparam logic signed [7:0] SPEED_MAX = 8'sd100;
  localparam logic signed [7:0] SPEED_MIN = -8'sd100;
  localparam logic [7:0]  ANGLE_MAX   = 8'd180;
  localparam logic [7:0]  ANGLE_RESET = 8'd90;
  localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
  localparam logic [15:0] TIMEOUT_RESET = 16'd2000;

  // bridge direction codes
  localparam logic [1:0] DIR_OFF = 2'd0;
  localparam logic [1:0] DIR_FWD = 2'd1;
  localparam logic [1:0] DIR_REV = 2'd2;

  // ceil(2^22 / 100): exact quotient for dividends up to 25500
  localparam logic [15:0] RECIP_100 = 16'd41944;

  typedef struct packed {
    logic              func;
    logic [7:0]        cmd_byte;
    logic [4:0]        frame_len;
    logic signed [7:0] left_arg;
    logic signed [7:0] right_arg;
    logic [7:0]        servo_arg;
  } mcw_req_t;

  typedef struct packed {
    logic              status_valid;
    logic signed [7:0] status_left;
    logic signed [7:0] status_right;
    logic [2:0]        status_flags;
    logic              frame_error;
    logic [1:0]        left_dir;
    logic [7:0]        left_duty;
    logic [1:0]        right_dir;
    logic [7:0]        right_duty;
    logic [7:0]        servo_angle;
    logic              stopped;
  } mcw_rsp_t;

  typedef struct packed {
    logic signed [7:0] left_speed;
    logic signed [7:0] right_speed;
    logic [7:0]        steer_angle;
    logic              stop_latch;
    logic [15:0]       ms_count;
  } mcw_state_t;

  // abs(speed) * 255 / 100 for a magnitude of 0..100
  function automatic logic [7:0] duty_of(input logic [6:0] mag);
    logic [14:0] scaled;
    logic [30:0] prod;
    scaled = {mag, 8'b0} - {8'b0, mag};
    prod   = {16'b0, scaled} * {15'b0, RECIP_100};
    return prod[29:22];
  endfunction

endpackage

@@ src/mcw_step.sv @@
// Next-state and result logic for one request of the motor controller.
// Depends on mcw_pkg.
module mcw_step (
  input  mcw_pkg::mcw_state_t state_i,
  input  mcw_pkg::mcw_req_t   req_i,
  input  logic [15:0]         timeout_i,
  output mcw_pkg::mcw_state_t state_o,
  output mcw_pkg::mcw_rsp_t   rsp_o
);
  import mcw_pkg::*;

  logic [15:0]       count_inc;
  logic signed [7:0] left_clamp;
  logic signed [7:0] right_clamp;
  logic [7:0]        angle_clamp;
  logic [7:0]        left_mag;
  logic [7:0]        right_mag;

  assign count_inc = (state_i.ms_count == COUNT_MAX) ? COUNT_MAX : state_i.ms_count + 16'd1;

  always_comb begin
    priority if (req_i.left_arg > SPEED_MAX) left_clamp = SPEED_MAX;
    else if (req_i.left_arg < SPEED_MIN)     left_clamp = SPEED_MIN;
    else                                     left_clamp = req_i.left_arg;
    priority if (req_i.right_arg > SPEED_MAX) right_clamp = SPEED_MAX;
    else if (req_i.right_arg < SPEED_MIN)     right_clamp = SPEED_MIN;
    else                                      right_clamp = req_i.right_arg;
    angle_clamp = (req_i.servo_arg > ANGLE_MAX) ? ANGLE_MAX : req_i.servo_arg;
  end

  always_comb begin
    state_o = state_i;
    rsp_o   = '0;
    if (req_i.func == FUNC_TICK) begin
      state_o.ms_count = count_inc;
      if (count_inc > timeout_i && !state_i.stop_latch &&
          (state_i.left_speed != 8'sd0 || state_i.right_speed != 8'sd0)) begin
        state_o.stop_latch  = 1'b1;
        state_o.left_speed  = 8'sd0;
        state_o.right_speed = 8'sd0;
      end
    end else if (req_i.frame_len != 5'd0) begin
      unique case (req_i.cmd_byte)
        CMD_SET: begin
          if (req_i.frame_len >= SET_MIN_LEN) begin
            state_o.left_speed  = left_clamp;
            state_o.right_speed = right_clamp;
            state_o.steer_angle = angle_clamp;
            state_o.stop_latch  = 1'b0;
            state_o.ms_count    = 16'd0;
          end else begin
            rsp_o.frame_error = 1'b1;
          end
        end
        CMD_STOP: begin
          state_o.stop_latch  = 1'b1;
          state_o.left_speed  = 8'sd0;
          state_o.right_speed = 8'sd0;
        end
        CMD_STATUS: begin
          rsp_o.status_valid = 1'b1;
          rsp_o.status_left  = state_i.left_speed;
          rsp_o.status_right = state_i.right_speed;
          rsp_o.status_flags = {state_i.stop_latch,
                                state_i.right_speed != 8'sd0,
                                state_i.left_speed != 8'sd0};
        end
        default: rsp_o.frame_error = 1'b1;
      endcase
    end

    // bridge outputs follow the state after the step
    left_mag  = state_o.left_speed[7]  ? 8'(-state_o.left_speed)  : state_o.left_speed;
    right_mag = state_o.right_speed[7] ? 8'(-state_o.right_speed) : state_o.right_speed;
    if (state_o.stop_latch || state_o.left_speed == 8'sd0) begin
      rsp_o.left_dir  = DIR_OFF;
      rsp_o.left_duty = 8'd0;
    end else begin
      rsp_o.left_dir  = state_o.left_speed[7] ? DIR_REV : DIR_FWD;
      rsp_o.left_duty = duty_of(left_mag[6:0]);
    end
    if (state_o.stop_latch || state_o.right_speed == 8'sd0) begin
      rsp_o.right_dir  = DIR_OFF;
      rsp_o.right_duty = 8'd0;
    end else begin
      rsp_o.right_dir  = state_o.right_speed[7] ? DIR_REV : DIR_FWD;
      rsp_o.right_duty = duty_of(right_mag[6:0]);
    end
    rsp_o.servo_angle = state_o.steer_angle;
    rsp_o.stopped     = state_o.stop_latch;
  end

endmodule

@@ src/motor_command_controller_with_watchdog_core.sv @@
// Motor command controller with watchdog: top level.
// Response: registered; a request's response appears in the cycle after it is accepted.
// Throughput: one request per cycle while the output is not stalled; the response register frees while it is taken.
// Reset: speeds 0, servo 90, stop clear, watchdog count 0, timeout 2000, output empty.
// Depends on mcw_pkg and mcw_step.
module motor_command_controller_with_watchdog_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mcw_pkg::mcw_req_t in_data_i,
  // response channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mcw_pkg::mcw_rsp_t out_data_o,
  // watchdog timeout register write
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [15:0]       cfg_data_i
);
  import mcw_pkg::*;

  mcw_state_t state_q, state_d;
  mcw_rsp_t   rsp_d, rsp_q;
  logic       out_valid_q, out_valid_d;
  logic [15:0] timeout_q;
  logic       in_accept;

  // The response register is the only buffer: a new request enters whenever the
  // register is empty or its contents leave in the same cycle.
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  mcw_step u_step (
    .state_i   (state_q),
    .req_i     (in_data_i),
    .timeout_i (timeout_q),
    .state_o   (state_d),
    .rsp_o     (rsp_d)
  );

  assign out_valid_d = in_accept || (out_valid_q && out_stall_i);

  // control state: controller state, timeout and response valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.left_speed  <= 8'sd0;
      state_q.right_speed <= 8'sd0;
      state_q.steer_angle <= ANGLE_RESET;
      state_q.stop_latch  <= 1'b0;
      state_q.ms_count    <= 16'd0;
      timeout_q           <= TIMEOUT_RESET;
      out_valid_q         <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_accept) begin
        state_q <= state_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

  // response payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = rsp_q;

endmodule

@@ verif/tb.sv @@
// Testbench for motor_command_controller_with_watchdog_core.
// It drives random and directed frames and ticks, predicts every response, and compares.
// Depends on mcw_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;
  import mcw_pkg::*;

  localparam int STUCK_LIMIT = 4000;  // cycles with no handshake at all
  localparam int MAX_REPORTS = 100;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  mcw_req_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  mcw_rsp_t    out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;

  motor_command_controller_with_watchdog_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the controller: speeds, servo, stop latch, watchdog count,
  // and the timeout register as last written.
  // ---------------------------------------------------------------------------
  logic signed [7:0] spd_left_q  = '0;
  logic signed [7:0] spd_right_q = '0;
  logic [7:0]        servo_q     = ANGLE_RESET;
  logic              estop_q     = 1'b0;
  logic [15:0]       idle_ms_q   = '0;
  logic [15:0]       timeout_ms_q = TIMEOUT_RESET;

  mcw_req_t pending_reqs [$];   // requests not yet put on the bus
  mcw_rsp_t predicted_rsps [$]; // responses owed by the core, oldest first

  int  mismatches = 0;
  int  reqs_taken = 0;
  int  rsps_checked = 0;
  int  watchdog_trips = 0;
  int  stuck_cycles = 0;
  bit  calm = 1'b0;       // no idling on either side
  bit  req_taken = 1'b0;  // request handshake at the last rising edge
  int  send_gap = 0;
  int  stall_left = 0;

  function automatic logic signed [7:0] clamp_speed(input logic signed [7:0] v);
    if (v > SPEED_MAX) return SPEED_MAX;
    if (v < SPEED_MIN) return SPEED_MIN;
    return v;
  endfunction

  // {dir, duty} for one bridge; off whenever stop is latched
  function automatic logic [9:0] bridge_drive(input logic signed [7:0] spd);
    int mag;
    if (estop_q || spd == 0) return {DIR_OFF, 8'd0};
    mag = (spd < 0) ? -int'(spd) : int'(spd);
    return {(spd > 0) ? DIR_FWD : DIR_REV, 8'(mag * 255 / 100)};
  endfunction

  // Applies one accepted request to the shadow state, returns the response.
  function automatic mcw_rsp_t advance_controller(input mcw_req_t r);
    mcw_rsp_t o;
    o = '0;
    if (r.func == FUNC_TICK) begin
      // count saturates; the other request fields mean nothing on a tick
      if (idle_ms_q != COUNT_MAX) idle_ms_q = idle_ms_q + 16'd1;
      if (idle_ms_q > timeout_ms_q && !estop_q && (spd_left_q != 0 || spd_right_q != 0)) begin
        estop_q = 1'b1;
        spd_left_q = '0;
        spd_right_q = '0;
        watchdog_trips++;
      end
    end else if (r.frame_len != 5'd0) begin
      case (r.cmd_byte)
        CMD_SET: begin
          if (r.frame_len >= SET_MIN_LEN) begin
            spd_left_q  = clamp_speed(r.left_arg);
            spd_right_q = clamp_speed(r.right_arg);
            servo_q     = (r.servo_arg > ANGLE_MAX) ? ANGLE_MAX : r.servo_arg;
            estop_q     = 1'b0;
            idle_ms_q   = '0;
          end else begin
            o.frame_error = 1'b1;
          end
        end
        CMD_STOP: begin
          estop_q = 1'b1;
          spd_left_q = '0;
          spd_right_q = '0;
        end
        CMD_STATUS: begin
          o.status_valid = 1'b1;
          o.status_left  = spd_left_q;
          o.status_right = spd_right_q;
          o.status_flags = {estop_q, spd_right_q != 0, spd_left_q != 0};
        end
        default: o.frame_error = 1'b1;
      endcase
    end
    {o.left_dir, o.left_duty}   = bridge_drive(spd_left_q);
    {o.right_dir, o.right_duty} = bridge_drive(spd_right_q);
    o.servo_angle = servo_q;
    o.stopped     = estop_q;
    return o;
  endfunction

  function automatic void check_field(input string name, input logic signed [31:0] want,
                                      input logic signed [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: response %0d %s expected %0d actual %0d",
                 $time, rsps_checked, name, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: everything sampled at the rising edge, before the core's
  // registers move. Response check first, then the new request is predicted.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    mcw_rsp_t want;
    bit moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (predicted_rsps.size() == 0) begin
          mismatches++;
          $display("%0t: response with none expected, actual %h", $time, out_data_o);
        end else begin
          want = predicted_rsps.pop_front();
          check_field("status_valid", 32'(want.status_valid), 32'(out_data_o.status_valid));
          check_field("status_left",  32'(want.status_left),  32'(out_data_o.status_left));
          check_field("status_right", 32'(want.status_right), 32'(out_data_o.status_right));
          check_field("status_flags", 32'(want.status_flags), 32'(out_data_o.status_flags));
          check_field("frame_error",  32'(want.frame_error),  32'(out_data_o.frame_error));
          check_field("left_dir",     32'(want.left_dir),     32'(out_data_o.left_dir));
          check_field("left_duty",    32'(want.left_duty),    32'(out_data_o.left_duty));
          check_field("right_dir",    32'(want.right_dir),    32'(out_data_o.right_dir));
          check_field("right_duty",   32'(want.right_duty),   32'(out_data_o.right_duty));
          check_field("servo_angle",  32'(want.servo_angle),  32'(out_data_o.servo_angle));
          check_field("stopped",      32'(want.stopped),      32'(out_data_o.stopped));
          rsps_checked++;
        end
      end
      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        predicted_rsps.push_back(advance_controller(in_data_i));
        reqs_taken++;
      end
      req_taken <= in_valid_i && !in_stall_o;
      // register writes happen only with the core idle
      if (cfg_valid_i && cfg_ready_o) begin
        moved = 1'b1;
        timeout_ms_q = cfg_data_i;
      end
    end
    // hang detector: a long stretch with no handshake of any kind
    stuck_cycles = moved ? 0 : stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STUCK_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver: moves on only when the current request was taken or
  // nothing is on the bus; random gap bursts go in between requests.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || req_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        if (!calm && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(1, 17) - 1;
          in_valid_i <= 1'b0;
        end else begin
          in_data_i  <= pending_reqs.pop_front();
          in_valid_i <= 1'b1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Response side: random stall bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(1, 17) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic mcw_req_t frame_req(input logic [7:0] cmd, input int len,
                                         input int l, input int r, input int s);
    mcw_req_t q;
    q.func      = FUNC_FRAME;
    q.cmd_byte  = cmd;
    q.frame_len = 5'(len);
    q.left_arg  = 8'(l);
    q.right_arg = 8'(r);
    q.servo_arg = 8'(s);
    return q;
  endfunction

  // tick with junk in the ignored fields
  function automatic mcw_req_t tick_req();
    mcw_req_t q;
    q = frame_req(8'($urandom), $urandom, $urandom, $urandom, $urandom);
    q.func = FUNC_TICK;
    return q;
  endfunction

  // speeds mostly inside the legal range, sometimes anywhere in the byte
  function automatic int rand_speed();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 200) - 100;
    return $urandom_range(0, 255);
  endfunction

  // Random mix: mostly well-formed set/stop/status frames and ticks, plus
  // short, empty, overlong and unknown frames.
  function automatic mcw_req_t rand_req();
    int pick;
    mcw_req_t q;
    pick = $urandom_range(0, 99);
    q = frame_req(CMD_SET, $urandom_range(4, 16), rand_speed(), rand_speed(),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 180));
    if (pick < 40) begin
      q = tick_req();
    end else if (pick < 68) begin
      if ($urandom_range(0, 9) == 0) q.frame_len = 5'($urandom_range(0, 31));
    end else if (pick < 77) begin
      q.cmd_byte = CMD_STOP;
      q.frame_len = 5'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                   : $urandom_range(1, 4));
    end else if (pick < 92) begin
      q.cmd_byte = CMD_STATUS;
      q.frame_len = 5'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                   : $urandom_range(1, 4));
    end else begin
      q.cmd_byte = 8'($urandom);
      q.frame_len = 5'($urandom_range(0, 31));
    end
    return q;
  endfunction

  // Returns once every request went out and every response came back.
  task automatic drain_all();
    do begin
      @(posedge clk_i);
      #1;
    end while (pending_reqs.size() != 0 || in_valid_i || predicted_rsps.size() != 0);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [15:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [15:0] timeouts [6];
    timeouts = '{16'd0, 16'd3, 16'd17, 16'd65535, 16'd40, 16'd1};
    timeouts[5] = 16'($urandom_range(1, 120));

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset timeout: every command, clamping at both ends,
    // empty, short, long and unknown frames, tick junk ignored.
    pending_reqs.push_back(frame_req(CMD_STATUS, 1, 0, 0, 0));
    pending_reqs.push_back(frame_req(CMD_SET, 0, 50, 50, 10));       // empty frame
    pending_reqs.push_back(frame_req(CMD_SET, 4, 127, -128, 255));   // clamp to extremes
    pending_reqs.push_back(frame_req(CMD_STATUS, 2, 0, 0, 0));
    pending_reqs.push_back(frame_req(CMD_SET, 3, 20, 20, 20));       // short set
    pending_reqs.push_back(frame_req(8'h00, 5, 0, 0, 0));            // unknown
    pending_reqs.push_back(frame_req(8'hFF, 31, -1, -1, 255));       // unknown, max len
    pending_reqs.push_back(frame_req(CMD_SET, 31, -100, 100, 180));
    pending_reqs.push_back(frame_req(CMD_SET, 16, 101, -101, 181));
    pending_reqs.push_back(frame_req(CMD_SET, 17, -1, 1, 0));         // long frame
    pending_reqs.push_back(tick_req());
    pending_reqs.push_back(frame_req(CMD_STOP, 1, 0, 0, 0));
    pending_reqs.push_back(frame_req(CMD_STATUS, 1, 0, 0, 0));
    pending_reqs.push_back(tick_req());
    pending_reqs.push_back(frame_req(CMD_STOP, 0, 0, 0, 0));          // empty stop
    pending_reqs.push_back(frame_req(CMD_SET, 4, 0, 0, 90));
    pending_reqs.push_back(frame_req(CMD_STATUS, 31, 0, 0, 0));
    pending_reqs.push_back(frame_req(CMD_SET, 5, 50, -50, 30));
    drain_all();

    // Zero timeout: the first tick after a set trips the watchdog.
    write_timeout(16'd0);
    pending_reqs.push_back(tick_req());
    pending_reqs.push_back(frame_req(CMD_STATUS, 1, 0, 0, 0));
    pending_reqs.push_back(frame_req(CMD_SET, 4, 10, 0, 100));
    pending_reqs.push_back(tick_req());
    pending_reqs.push_back(frame_req(CMD_STATUS, 3, 0, 0, 0));
    drain_all();

    // Random phases, each under its own timeout, with idling on both sides.
    for (int p = 0; p < 5; p++) begin
      write_timeout(timeouts[p]);
      repeat (140) pending_reqs.push_back(rand_req());
      drain_all();
    end

    // Largest timeouts: a run of ticks leaves the motors running.
    calm = 1'b1;
    write_timeout(COUNT_MAX);
    pending_reqs.push_back(frame_req(CMD_SET, 4, 60, -60, 45));
    repeat (20) pending_reqs.push_back(tick_req());
    pending_reqs.push_back(frame_req(CMD_STATUS, 1, 0, 0, 0));
    drain_all();
    write_timeout(COUNT_MAX - 16'd1);
    pending_reqs.push_back(tick_req());
    pending_reqs.push_back(frame_req(CMD_STATUS, 1, 0, 0, 0));
    drain_all();

    // Final stretch: back to back, no idling.
    write_timeout(timeouts[5]);
    repeat (140) pending_reqs.push_back(rand_req());
    drain_all();
    repeat (4) @(posedge clk_i);

    $display("tb: %0d requests, %0d responses checked, %0d watchdog trips",
             reqs_taken, rsps_checked, watchdog_trips);
    $display("tb: timeouts from 0 up to 65535, stalls and gaps; %0d mismatches", mismatches);
    if (mismatches == 0 && predicted_rsps.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
